### rtl/core/lpmf_pkg.sv
// Shared constants, types and ring arithmetic of the length-prefixed message FIFO.
package lpmf_pkg;

  localparam int unsigned BufferBytes = 8192;
  localparam int unsigned PtrW        = $clog2(BufferBytes);
  localparam int unsigned HdrBytes    = 4;
  localparam int unsigned HdrCntW     = $clog2(HdrBytes);

  localparam int unsigned FuncW   = 2;
  localparam int unsigned LenW    = 16;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned OffsW   = 13;
  localparam int unsigned StatusW = 2;
  localparam int unsigned UsedW   = 13;
  localparam int unsigned IdW     = 32;

  localparam int unsigned SumW = ((PtrW > LenW) ? PtrW : LenW) + 2;

  typedef enum logic [FuncW-1:0] {
    FuncStart,
    FuncAppend,
    FuncRead,
    FuncDelete
  } func_e;

  typedef enum logic [StatusW-1:0] {
    StatusOk,
    StatusNoRoom,
    StatusEmpty,
    StatusIgnored
  } status_e;

  typedef enum logic [2:0] {
    StIdle,
    StExec,
    StHdr,
    StLenLo,
    StLenHi,
    StEval,
    StRdData,
    StDone
  } state_e;

  typedef struct packed {
    status_e              status;
    logic [ByteW-1:0]     read_data;
    logic                 queue_empty;
    logic [UsedW-1:0]     used_bytes;
    logic [IdW-1:0]       message_id;
  } res_t;

  function automatic logic [PtrW-1:0] ring_add(logic [PtrW-1:0] base, logic [PtrW-1:0] k);
    logic [PtrW:0] sum;
    sum = {1'b0, base} + {1'b0, k};
    if (sum >= (PtrW+1)'(BufferBytes)) begin
      sum = sum - (PtrW+1)'(BufferBytes);
    end
    return sum[PtrW-1:0];
  endfunction

endpackage

### rtl/core/lpmf_in_if.sv
// Input channel: command items with valid/ready handshake.
interface lpmf_in_if;
  logic                          valid;
  logic                          ready;
  logic [lpmf_pkg::FuncW-1:0]    func;
  logic [lpmf_pkg::LenW-1:0]     msg_length;
  logic [lpmf_pkg::ByteW-1:0]    data_byte;
  logic [lpmf_pkg::OffsW-1:0]    read_offset;

  modport source (output valid, output func, output msg_length, output data_byte,
                  output read_offset, input ready);
  modport sink   (input valid, input func, input msg_length, input data_byte,
                  input read_offset, output ready);
endinterface

### rtl/core/lpmf_out_if.sv
// Output channel: result items with valid/ready handshake.
interface lpmf_out_if;
  logic                          valid;
  logic                          ready;
  logic [lpmf_pkg::StatusW-1:0]  status;
  logic [lpmf_pkg::ByteW-1:0]    read_data;
  logic                          queue_empty;
  logic [lpmf_pkg::UsedW-1:0]    used_bytes;
  logic [lpmf_pkg::IdW-1:0]      message_id;

  modport source (output valid, output status, output read_data, output queue_empty,
                  output used_bytes, output message_id, input ready);
  modport sink   (input valid, input status, input read_data, input queue_empty,
                  input used_bytes, input message_id, output ready);
endinterface

### rtl/core/lpmf_ram.sv
// Generic single-port synchronous RAM with registered read.
module lpmf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/lpmf_ctrl.sv
// Sequencer that applies commands to the ring pointers and the byte store.
module lpmf_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  lpmf_in_if.sink                        in_i,
  output lpmf_pkg::res_t                 res_o,
  output logic                           res_valid_o,
  input  logic                           res_ready_i,
  output logic                           ram_we_o,
  output logic [lpmf_pkg::PtrW-1:0]      ram_addr_o,
  output logic [lpmf_pkg::ByteW-1:0]     ram_wdata_o,
  input  logic [lpmf_pkg::ByteW-1:0]     ram_rdata_i
);

  lpmf_pkg::state_e                 state_q, state_d;
  logic [lpmf_pkg::PtrW-1:0]        head_q, head_d;
  logic [lpmf_pkg::PtrW-1:0]        tail_q, tail_d;
  logic [lpmf_pkg::PtrW-1:0]        occ_q, occ_d;
  logic [lpmf_pkg::IdW-1:0]         del_q, del_d;
  logic [lpmf_pkg::LenW-1:0]        rem_q, rem_d;
  logic                             open_q, open_d;
  logic [lpmf_pkg::HdrCntW-1:0]     hdr_cnt_q, hdr_cnt_d;

  lpmf_pkg::func_e                  func_q;
  logic [lpmf_pkg::LenW-1:0]        len_q;
  logic [lpmf_pkg::ByteW-1:0]       byte_q;
  logic [lpmf_pkg::OffsW-1:0]       offs_q;
  logic [lpmf_pkg::ByteW-1:0]       lo_q, lo_d;
  logic [lpmf_pkg::SumW-1:0]        total_q, total_d;
  lpmf_pkg::status_e                status_q, status_d;
  logic [lpmf_pkg::ByteW-1:0]       rdata_q, rdata_d;

  logic                             in_xfer;

  assign in_i.ready = (state_q == lpmf_pkg::StIdle);
  assign in_xfer    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= lpmf_pkg::StIdle;
      head_q    <= '0;
      tail_q    <= '0;
      occ_q     <= '0;
      del_q     <= '0;
      rem_q     <= '0;
      open_q    <= 1'b0;
      hdr_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      occ_q     <= occ_d;
      del_q     <= del_d;
      rem_q     <= rem_d;
      open_q    <= open_d;
      hdr_cnt_q <= hdr_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      func_q <= lpmf_pkg::func_e'(in_i.func);
      len_q  <= in_i.msg_length;
      byte_q <= in_i.data_byte;
      offs_q <= in_i.read_offset;
    end
    lo_q     <= lo_d;
    total_q  <= total_d;
    status_q <= status_d;
    rdata_q  <= rdata_d;
  end

  always_comb begin
    logic [lpmf_pkg::SumW-1:0] occ_w;
    logic [lpmf_pkg::SumW-1:0] present;
    logic [lpmf_pkg::PtrW-1:0] tot;
    logic                      head_open;

    occ_w     = lpmf_pkg::SumW'(occ_q);
    present   = '0;
    tot       = '0;
    head_open = 1'b0;

    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    occ_d       = occ_q;
    del_d       = del_q;
    rem_d       = rem_q;
    open_d      = open_q;
    hdr_cnt_d   = hdr_cnt_q;
    lo_d        = lo_q;
    total_d     = total_q;
    status_d    = status_q;
    rdata_d     = rdata_q;
    ram_we_o    = 1'b0;
    ram_addr_o  = head_q;
    ram_wdata_o = '0;
    res_valid_o = 1'b0;

    case (state_q)
      lpmf_pkg::StIdle: begin
        if (in_xfer) begin
          state_d = lpmf_pkg::StExec;
        end
      end

      lpmf_pkg::StExec: begin
        rdata_d  = '0;
        status_d = lpmf_pkg::StatusOk;
        state_d  = lpmf_pkg::StDone;
        case (func_q)
          lpmf_pkg::FuncStart: begin
            if (open_q) begin
              status_d = lpmf_pkg::StatusIgnored;
            end else if (occ_w + lpmf_pkg::SumW'(len_q) + lpmf_pkg::SumW'(lpmf_pkg::HdrBytes)
                         >= lpmf_pkg::SumW'(lpmf_pkg::BufferBytes)) begin
              status_d = lpmf_pkg::StatusNoRoom;
            end else begin
              occ_d     = occ_q + lpmf_pkg::PtrW'(len_q) + lpmf_pkg::PtrW'(lpmf_pkg::HdrBytes);
              rem_d     = len_q;
              open_d    = (len_q != '0);
              hdr_cnt_d = '0;
              state_d   = lpmf_pkg::StHdr;
            end
          end
          lpmf_pkg::FuncAppend: begin
            if (!open_q) begin
              status_d = lpmf_pkg::StatusIgnored;
            end else begin
              ram_we_o    = 1'b1;
              ram_addr_o  = tail_q;
              ram_wdata_o = byte_q;
              tail_d      = lpmf_pkg::ring_add(tail_q, lpmf_pkg::PtrW'(1));
              rem_d       = rem_q - lpmf_pkg::LenW'(1);
              if (rem_q == lpmf_pkg::LenW'(1)) begin
                open_d = 1'b0;
              end
            end
          end
          lpmf_pkg::FuncRead, lpmf_pkg::FuncDelete: begin
            if (occ_q == '0) begin
              status_d = lpmf_pkg::StatusEmpty;
            end else begin
              ram_addr_o = head_q;
              state_d    = lpmf_pkg::StLenLo;
            end
          end
          default: begin
            state_d = lpmf_pkg::StDone;
          end
        endcase
      end

      lpmf_pkg::StHdr: begin
        ram_we_o   = 1'b1;
        ram_addr_o = tail_q;
        case (hdr_cnt_q)
          lpmf_pkg::HdrCntW'(0): ram_wdata_o = len_q[lpmf_pkg::ByteW-1:0];
          lpmf_pkg::HdrCntW'(1): ram_wdata_o = len_q[lpmf_pkg::LenW-1:lpmf_pkg::ByteW];
          default:               ram_wdata_o = '0;
        endcase
        tail_d    = lpmf_pkg::ring_add(tail_q, lpmf_pkg::PtrW'(1));
        hdr_cnt_d = hdr_cnt_q + lpmf_pkg::HdrCntW'(1);
        if (hdr_cnt_q == lpmf_pkg::HdrCntW'(lpmf_pkg::HdrBytes - 1)) begin
          state_d = lpmf_pkg::StDone;
        end
      end

      lpmf_pkg::StLenLo: begin
        lo_d       = ram_rdata_i;
        ram_addr_o = lpmf_pkg::ring_add(head_q, lpmf_pkg::PtrW'(1));
        state_d    = lpmf_pkg::StLenHi;
      end

      lpmf_pkg::StLenHi: begin
        total_d = lpmf_pkg::SumW'({ram_rdata_i, lo_q}) + lpmf_pkg::SumW'(lpmf_pkg::HdrBytes);
        state_d = lpmf_pkg::StEval;
      end

      lpmf_pkg::StEval: begin
        state_d = lpmf_pkg::StDone;
        if (func_q == lpmf_pkg::FuncRead) begin
          head_open = open_q && (total_q == occ_w);
          present   = head_open ? (total_q - lpmf_pkg::SumW'(rem_q)) : total_q;
          if (lpmf_pkg::SumW'(offs_q) < present) begin
            ram_addr_o = lpmf_pkg::ring_add(head_q, lpmf_pkg::PtrW'(offs_q));
            state_d    = lpmf_pkg::StRdData;
          end
        end else begin
          tot = (total_q > occ_w) ? occ_q : lpmf_pkg::PtrW'(total_q);
          if (open_q && (tot == occ_q)) begin
            open_d = 1'b0;
            rem_d  = '0;
            tail_d = lpmf_pkg::ring_add(head_q, tot);
          end
          head_d = lpmf_pkg::ring_add(head_q, tot);
          occ_d  = occ_q - tot;
          del_d  = del_q + lpmf_pkg::IdW'(1);
        end
      end

      lpmf_pkg::StRdData: begin
        rdata_d = ram_rdata_i;
        state_d = lpmf_pkg::StDone;
      end

      lpmf_pkg::StDone: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = lpmf_pkg::StIdle;
        end
      end

      default: begin
        state_d = lpmf_pkg::StIdle;
      end
    endcase
  end

  assign res_o.status      = status_q;
  assign res_o.read_data   = rdata_q;
  assign res_o.queue_empty = (occ_q == '0);
  assign res_o.used_bytes  = lpmf_pkg::UsedW'(occ_q);
  assign res_o.message_id  = del_q;

endmodule

### rtl/core/length_prefixed_message_fifo.sv
// Length-prefixed message FIFO top level: sequencer, byte store and result register.
// Messages live in a ring of 8192 bytes, each as a 4-byte header (length low, length
// high, two zero bytes) followed by its data. One command is worked at a time against
// the single-port byte store, so the wait from one input transfer to the next is set
// by the store accesses it needs and stalls: append writes one data byte; a command
// that is refused or finds the queue empty needs none; start makes four header
// writes; delete makes two header reads; read makes two header reads and one data
// read, and skips the data read when the offset lies past the bytes written so far.
// Every command gives exactly one result, held in an output register so a new command
// is taken while the previous result waits. The store needs no clearing after reset.
module length_prefixed_message_fifo (
  input  logic       clk_i,
  input  logic       rst_ni,
  lpmf_in_if.sink    in_i,
  lpmf_out_if.source out_o
);

  lpmf_pkg::res_t                 res;
  logic                           res_valid;
  logic                           res_ready;
  logic                           ram_we;
  logic [lpmf_pkg::PtrW-1:0]      ram_addr;
  logic [lpmf_pkg::ByteW-1:0]     ram_wdata;
  logic [lpmf_pkg::ByteW-1:0]     ram_rdata;

  logic                           out_valid_q;
  lpmf_pkg::res_t                 out_q;

  lpmf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .res_o       (res),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .ram_we_o    (ram_we),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata),
    .ram_rdata_i (ram_rdata)
  );

  lpmf_ram #(
    .Width (lpmf_pkg::ByteW),
    .Depth (lpmf_pkg::BufferBytes)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_q.status;
  assign out_o.read_data   = out_q.read_data;
  assign out_o.queue_empty = out_q.queue_empty;
  assign out_o.used_bytes  = out_q.used_bytes;
  assign out_o.message_id  = out_q.message_id;

endmodule

### tb/tb_top.sv
// Self-checking testbench of the length-prefixed message FIFO: directed corners, then random traffic.
`timescale 1ns / 100ps
module tb_top;

  localparam int unsigned CycleLimit   = 600000;
  localparam int unsigned SettleCycles = 32;
  localparam int unsigned OffsMax      = (1 << lpmf_pkg::OffsW) - 1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic drain_ready = 1'b0;

  lpmf_in_if  cmd_if ();
  lpmf_out_if rsp_if ();

  assign rsp_if.ready = drain_ready;

  length_prefixed_message_fifo uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (cmd_if),
    .out_o  (rsp_if)
  );

  always #6 clk = ~clk;

  logic [lpmf_pkg::ByteW-1:0] mirror_bytes [lpmf_pkg::BufferBytes];
  logic [lpmf_pkg::PtrW-1:0]  mirror_head = '0;
  logic [lpmf_pkg::PtrW-1:0]  mirror_tail = '0;
  int unsigned                mirror_used = 0;
  int unsigned                mirror_left = 0;
  logic [lpmf_pkg::IdW-1:0]   mirror_deleted = '0;
  logic                       mirror_open = 1'b0;

  lpmf_pkg::res_t replies_due [$];
  lpmf_pkg::res_t oldest_due;
  int unsigned    feed_idle_pct = 0;
  int unsigned    drain_stall_pct = 0;
  int unsigned    cmds_sent = 0;
  int unsigned    mismatches = 0;
  int unsigned    cycle_count = 0;

  function automatic logic [lpmf_pkg::PtrW-1:0] ring_pos(logic [lpmf_pkg::PtrW-1:0] base,
                                                         int unsigned k);
    return lpmf_pkg::PtrW'((int'(base) + k) % lpmf_pkg::BufferBytes);
  endfunction

  function automatic int unsigned head_span();
    return int'({mirror_bytes[ring_pos(mirror_head, 1)],
                 mirror_bytes[ring_pos(mirror_head, 0)]}) + lpmf_pkg::HdrBytes;
  endfunction

  function automatic lpmf_pkg::res_t predict_fifo_reply(lpmf_pkg::func_e op,
                                                        logic [lpmf_pkg::LenW-1:0] len,
                                                        logic [lpmf_pkg::ByteW-1:0] data,
                                                        logic [lpmf_pkg::OffsW-1:0] offs);
    lpmf_pkg::res_t r;
    int unsigned    span;
    int unsigned    present;
    r = '0;
    r.status = lpmf_pkg::StatusOk;
    case (op)
      lpmf_pkg::FuncStart: begin
        if (mirror_open) begin
          r.status = lpmf_pkg::StatusIgnored;
        end else if (mirror_used + len + lpmf_pkg::HdrBytes >= lpmf_pkg::BufferBytes) begin
          r.status = lpmf_pkg::StatusNoRoom;
        end else begin
          mirror_bytes[ring_pos(mirror_tail, 0)] = len[7:0];
          mirror_bytes[ring_pos(mirror_tail, 1)] = len[15:8];
          mirror_bytes[ring_pos(mirror_tail, 2)] = '0;
          mirror_bytes[ring_pos(mirror_tail, 3)] = '0;
          mirror_tail = ring_pos(mirror_tail, lpmf_pkg::HdrBytes);
          mirror_used += len + lpmf_pkg::HdrBytes;
          mirror_left = int'(len);
          mirror_open = (len != 0);
        end
      end
      lpmf_pkg::FuncAppend: begin
        if (!mirror_open) begin
          r.status = lpmf_pkg::StatusIgnored;
        end else begin
          mirror_bytes[mirror_tail] = data;
          mirror_tail = ring_pos(mirror_tail, 1);
          mirror_left -= 1;
          if (mirror_left == 0) begin
            mirror_open = 1'b0;
          end
        end
      end
      default: begin
        if (mirror_used == 0) begin
          r.status = lpmf_pkg::StatusEmpty;
        end else if (op == lpmf_pkg::FuncRead) begin
          span = head_span();
          present = span;
          if (mirror_open && span == mirror_used) begin
            present = span - mirror_left;
          end
          if (offs < present) begin
            r.read_data = mirror_bytes[ring_pos(mirror_head, int'(offs))];
          end
        end else begin
          span = head_span();
          if (span > mirror_used) begin
            span = mirror_used;
          end
          if (mirror_open && span == mirror_used) begin
            mirror_open = 1'b0;
            mirror_left = 0;
            mirror_tail = ring_pos(mirror_head, span);
          end
          mirror_head = ring_pos(mirror_head, span);
          mirror_used -= span;
          mirror_deleted += 1;
        end
      end
    endcase
    r.queue_empty = (mirror_used == 0);
    r.used_bytes  = lpmf_pkg::UsedW'(mirror_used);
    r.message_id  = mirror_deleted;
    return r;
  endfunction

  task automatic send_cmd(input lpmf_pkg::func_e op, input logic [lpmf_pkg::LenW-1:0] len,
                          input logic [lpmf_pkg::ByteW-1:0] data,
                          input logic [lpmf_pkg::OffsW-1:0] offs);
    while ($urandom_range(99) < feed_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_if.valid       <= 1'b1;
    cmd_if.func        <= op;
    cmd_if.msg_length  <= len;
    cmd_if.data_byte   <= data;
    cmd_if.read_offset <= offs;
    @(posedge clk);
    while (!cmd_if.ready) begin
      @(posedge clk);
    end
    replies_due.push_back(predict_fifo_reply(op, len, data, offs));
    cmds_sent++;
  endtask

  task automatic pause_until_drained();
    cmd_if.valid <= 1'b0;
    @(posedge clk);
    while (replies_due.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic check_field(input string name, input logic [lpmf_pkg::IdW-1:0] want,
                             input logic [lpmf_pkg::IdW-1:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    drain_ready <= rst_n && ($urandom_range(99) >= drain_stall_pct);
    if (rst_n && rsp_if.valid && drain_ready) begin
      if (replies_due.size() == 0) begin
        mismatches++;
        $display("%0t: result expected none, got status %0d used %0d", $time,
                 rsp_if.status, rsp_if.used_bytes);
      end else begin
        oldest_due = replies_due.pop_front();
        check_field("status", lpmf_pkg::IdW'(oldest_due.status),
                    lpmf_pkg::IdW'(rsp_if.status));
        check_field("read_data", lpmf_pkg::IdW'(oldest_due.read_data),
                    lpmf_pkg::IdW'(rsp_if.read_data));
        check_field("queue_empty", lpmf_pkg::IdW'(oldest_due.queue_empty),
                    lpmf_pkg::IdW'(rsp_if.queue_empty));
        check_field("used_bytes", lpmf_pkg::IdW'(oldest_due.used_bytes),
                    lpmf_pkg::IdW'(rsp_if.used_bytes));
        check_field("message_id", oldest_due.message_id, rsp_if.message_id);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic read_head_byte();
    int unsigned lim;
    lim = (mirror_used == 0) ? 8 : head_span() + 2;
    if (lim > OffsMax) begin
      lim = OffsMax;
    end
    send_cmd(lpmf_pkg::FuncRead, lpmf_pkg::LenW'($urandom), lpmf_pkg::ByteW'($urandom),
             lpmf_pkg::OffsW'($urandom_range(lim)));
  endtask

  task automatic test_empty_queue();
    send_cmd(lpmf_pkg::FuncRead, '1, 8'h00, '0);
    send_cmd(lpmf_pkg::FuncRead, '0, 8'hFF, '1);
    send_cmd(lpmf_pkg::FuncDelete, '0, '0, '0);
    send_cmd(lpmf_pkg::FuncAppend, '1, 8'hFF, '1);
  endtask

  task automatic test_length_limits();
    send_cmd(lpmf_pkg::FuncStart, '1, '0, '0);
    send_cmd(lpmf_pkg::FuncStart, lpmf_pkg::LenW'(lpmf_pkg::BufferBytes - lpmf_pkg::HdrBytes),
             '0, '0);
    send_cmd(lpmf_pkg::FuncStart,
             lpmf_pkg::LenW'(lpmf_pkg::BufferBytes - lpmf_pkg::HdrBytes - 1), '0, '0);
    send_cmd(lpmf_pkg::FuncStart, '0, '0, '0);
    send_cmd(lpmf_pkg::FuncAppend, '0, 8'h00, '0);
    send_cmd(lpmf_pkg::FuncAppend, '0, 8'hFF, '0);
    // header, both data bytes, then past the written part
    for (int k = 0; k < 7; k++) begin
      send_cmd(lpmf_pkg::FuncRead, '0, '0, lpmf_pkg::OffsW'(k));
    end
    send_cmd(lpmf_pkg::FuncRead, '0, '0, '1);
    send_cmd(lpmf_pkg::FuncDelete, '0, '0, '0);
    send_cmd(lpmf_pkg::FuncAppend, '0, 8'h5A, '0);
  endtask

  task automatic test_zero_length();
    send_cmd(lpmf_pkg::FuncStart, '0, '0, '0);
    send_cmd(lpmf_pkg::FuncAppend, '0, 8'hA5, '0);
    send_cmd(lpmf_pkg::FuncRead, '0, '0, lpmf_pkg::OffsW'(3));
    send_cmd(lpmf_pkg::FuncRead, '0, '0, lpmf_pkg::OffsW'(4));
    send_cmd(lpmf_pkg::FuncDelete, '0, '0, '0);
  endtask

  // empty the queue, try to reserve a large message and, if taken, touch it and delete it while open
  task automatic sweep_ring();
    int unsigned len;
    while (mirror_used != 0) begin
      send_cmd(lpmf_pkg::FuncDelete, lpmf_pkg::LenW'($urandom), lpmf_pkg::ByteW'($urandom),
               lpmf_pkg::OffsW'($urandom));
    end
    case ($urandom_range(5))
      0: len = lpmf_pkg::BufferBytes - lpmf_pkg::HdrBytes - 1;
      1: len = lpmf_pkg::BufferBytes - lpmf_pkg::HdrBytes;
      default: len = $urandom_range(lpmf_pkg::BufferBytes - lpmf_pkg::HdrBytes - 1, 1000);
    endcase
    send_cmd(lpmf_pkg::FuncStart, lpmf_pkg::LenW'(len), lpmf_pkg::ByteW'($urandom),
             lpmf_pkg::OffsW'($urandom));
    repeat ($urandom_range(3)) begin
      send_cmd(lpmf_pkg::FuncAppend, lpmf_pkg::LenW'($urandom), lpmf_pkg::ByteW'($urandom),
               lpmf_pkg::OffsW'($urandom));
    end
    repeat ($urandom_range(3)) begin
      read_head_byte();
    end
    send_cmd(lpmf_pkg::FuncDelete, lpmf_pkg::LenW'($urandom), lpmf_pkg::ByteW'($urandom),
             lpmf_pkg::OffsW'($urandom));
  endtask

  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
                                     input int unsigned count);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned len;
    feed_idle_pct = idle_pct;
    drain_stall_pct = stall_pct;
    stop_at = cmds_sent + count;
    while (cmds_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        // close a long open message by deleting up to it, finish a short one
        if (mirror_open && mirror_left > 64) begin
          while (mirror_open) begin
            send_cmd(lpmf_pkg::FuncDelete, lpmf_pkg::LenW'($urandom),
                     lpmf_pkg::ByteW'($urandom), lpmf_pkg::OffsW'($urandom));
          end
        end
        while (mirror_open) begin
          send_cmd(lpmf_pkg::FuncAppend, lpmf_pkg::LenW'($urandom),
                   lpmf_pkg::ByteW'($urandom), lpmf_pkg::OffsW'($urandom));
        end
        case ($urandom_range(19))
          0: len = $urandom_range(65535);
          1, 2, 3: len = $urandom_range(120, 17);
          default: len = $urandom_range(16);
        endcase
        send_cmd(lpmf_pkg::FuncStart, lpmf_pkg::LenW'(len), lpmf_pkg::ByteW'($urandom),
                 lpmf_pkg::OffsW'($urandom));
        if (!mirror_open || len > 120) begin
          len = (len == 0) ? 0 : $urandom_range(3);
        end else if ($urandom_range(19) == 0) begin
          len = $urandom_range(len);
        end
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(9) == 0) begin
            read_head_byte();
          end
          send_cmd(lpmf_pkg::FuncAppend, lpmf_pkg::LenW'($urandom),
                   lpmf_pkg::ByteW'($urandom), lpmf_pkg::OffsW'($urandom));
        end
      end else if (pick < 70) begin
        read_head_byte();
      end else if (pick < 84) begin
        send_cmd(lpmf_pkg::FuncDelete, lpmf_pkg::LenW'($urandom), lpmf_pkg::ByteW'($urandom),
                 lpmf_pkg::OffsW'($urandom));
      end else if (pick < 90) begin
        sweep_ring();
      end else begin
        send_cmd(lpmf_pkg::func_e'($urandom_range(3)), lpmf_pkg::LenW'($urandom),
                 lpmf_pkg::ByteW'($urandom), lpmf_pkg::OffsW'($urandom));
      end
    end
  endtask

  initial begin
    cmd_if.valid       <= 1'b0;
    cmd_if.func        <= lpmf_pkg::FuncStart;
    cmd_if.msg_length  <= '0;
    cmd_if.data_byte   <= '0;
    cmd_if.read_offset <= '0;
    foreach (mirror_bytes[i]) begin
      mirror_bytes[i] = '0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_queue();
    test_length_limits();
    test_zero_length();
    pause_until_drained();
    test_random_traffic(0, 0, 380);
    pause_until_drained();
    test_random_traffic(77, 0, 380);
    pause_until_drained();
    test_random_traffic(0, 77, 380);
    pause_until_drained();
    test_random_traffic(36, 36, 380);
    pause_until_drained();
    repeat (SettleCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/lpmf_pkg.sv
rtl/core/lpmf_in_if.sv
rtl/core/lpmf_out_if.sv
rtl/core/lpmf_ram.sv
rtl/core/lpmf_ctrl.sv
rtl/core/length_prefixed_message_fifo.sv
tb/tb_top.sv
